// File: rtl/core/spectral_bin_recalibration_top_macros.svh
// ----------------------------------------------------------------------------
// spectral_bin_recalibration_top_macros
// assertion macros shared by the recalibration rtl
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_BIN_RECALIBRATION_TOP_MACROS_SVH
`define SPECTRAL_BIN_RECALIBRATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked property, off while reset is high
`define SBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also live during reset
`define SBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBR_ASSERT(label, prop, msg)
`define SBR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/core/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// types, widths and codes of the spectral bin recalibration block
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  localparam int MAX_BINS_DEF = 4096;

  localparam int BIN_W   = 12;
  localparam int D_W     = 32;
  localparam int GAIN_W  = 18;
  localparam int ENTRY_W = 2 * D_W;
  localparam int DEN_W   = 68;
  localparam int Q_W     = 33;
  localparam int MAG_W   = 117;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  localparam logic signed [D_W-1:0] SAT_MAX = {1'b0, {(D_W-1){1'b1}}};
  localparam logic signed [D_W-1:0] SAT_MIN = {1'b1, {(D_W-1){1'b0}}};

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_CAL  = 1'b1
  } action_t;

  typedef enum logic {
    REG_SENSING_GAIN   = 1'b0,
    REG_OPEN_LOOP_GAIN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             last;
  } meta_t;

  // one division lane: partial remainder and numerator/quotient shifter
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   sh;
    logic             neg;
    logic             big;
  } lane_t;

  // zero-divisor fallback: sign and zero of the numerator product
  typedef struct packed {
    logic zd;
    logic tz_re;
    logic tn_re;
    logic tz_im;
    logic tn_im;
  } flag_t;

endpackage

`default_nettype wire

// File: rtl/core/spectral_bin_recalibration_top.sv
// ----------------------------------------------------------------------------
// spectral_bin_recalibration_top
// per-bin response/sensing tables and a pipelined complex recalibration
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  in        in_valid/in_ready + item fields  load or calibrate item in
//  out       out_valid/out_ready + results    one result per calibrate item
//  cfg       cfg_we, cfg_index, cfg_wdata     gain register writes
//
//  one item per cycle while the output is not stalled; 48 register stages:
//  a ram read, 12 arithmetic stages, the 33-stage restoring divider, then
//  rounding and saturation
//  tables sit in two rams (depth MAX_BINS); a load writes at its accept
//  edge, so a calibrate right behind it already reads the new entry
//  reset clears valids and gains only; table entries are undefined until
//  loaded. a full output that is not taken holds the whole pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_bin_recalibration_top #(
  parameter int MAX_BINS = sbr_pkg::MAX_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [sbr_pkg::GAIN_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [sbr_pkg::BIN_W-1:0]          bin_index,
  input  logic signed [sbr_pkg::D_W-1:0]     ref_resp_re,
  input  logic signed [sbr_pkg::D_W-1:0]     ref_resp_im,
  input  logic signed [sbr_pkg::D_W-1:0]     ref_sens_re,
  input  logic signed [sbr_pkg::D_W-1:0]     ref_sens_im,
  input  logic signed [sbr_pkg::D_W-1:0]     data_re,
  input  logic signed [sbr_pkg::D_W-1:0]     data_im,
  input  logic                               last_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sbr_pkg::D_W-1:0]     cal_re,
  output logic signed [sbr_pkg::D_W-1:0]     cal_im,
  output logic [sbr_pkg::BIN_W-1:0]          bin_out,
  output logic                               zero_divisor,
  output logic                               last_out
);

  import sbr_pkg::*;

  `include "spectral_bin_recalibration_top_macros.svh"

  localparam int AW        = $clog2(MAX_BINS);
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_BASE  = 13;
  localparam int LAT       = DIV_BASE + DIV_STEPS + 2;

  localparam logic signed [65:0] ONE_Q46 = 66'sd1 <<< 46;
  localparam logic signed [85:0] NR_BIAS = (86'sd1 <<< 62) + (86'sd1 <<< 38);
  localparam logic signed [85:0] NI_BIAS = 86'sd1 <<< 38;
  localparam logic signed [51:0] CS_BIAS = 52'sd1 <<< 15;

  // ---------------- configuration
  logic [GAIN_W-1:0] sensing_gain;
  logic [GAIN_W-1:0] open_loop_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensing_gain   <= GAIN_RESET;
      open_loop_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSING_GAIN:   sensing_gain   <= cfg_wdata;
        REG_OPEN_LOOP_GAIN: open_loop_gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- handshake and control pipe
  logic           en;
  logic           in_acc;
  logic           in_acc_cal;
  logic [LAT:1]   vld;
  meta_t          meta [1:LAT];
  logic [AW-1:0]  slot;

  assign en         = !vld[LAT] || out_ready;
  assign in_ready   = en;
  assign in_acc     = in_valid && in_ready;
  assign in_acc_cal = in_acc && (action == ACT_CAL);
  assign slot       = AW'(bin_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_acc_cal};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[1] <= '{bin: bin_index, last: last_in};
      for (int k = 1; k < LAT; k++) begin
        meta[k+1] <= meta[k];
      end
    end
  end

  // ---------------- tables
  logic [ENTRY_W-1:0] resp_q;
  logic [ENTRY_W-1:0] sens_q;
  logic               tbl_we;

  assign tbl_we = in_acc && (action == ACT_LOAD);

  sbr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BINS)) u_resp_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot),
    .wdata ({ref_resp_im, ref_resp_re}),
    .re    (in_acc),
    .raddr (slot),
    .rdata (resp_q)
  );

  sbr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BINS)) u_sens_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot),
    .wdata ({ref_sens_im, ref_sens_re}),
    .re    (in_acc),
    .raddr (slot),
    .rdata (sens_q)
  );

  // ---------------- arithmetic stages
  logic signed [D_W-1:0] s1_dr, s1_di;
  logic signed [D_W-1:0] s1_rr, s1_ri, s1_cr, s1_ci;

  assign s1_rr = $signed(resp_q[D_W-1:0]);
  assign s1_ri = $signed(resp_q[ENTRY_W-1:D_W]);
  assign s1_cr = $signed(sens_q[D_W-1:0]);
  assign s1_ci = $signed(sens_q[ENTRY_W-1:D_W]);

  logic signed [63:0]    s2_p_rr, s2_p_ii, s2_p_ri, s2_p_ir;
  logic signed [50:0]    s2_csr_raw, s2_csi_raw;
  logic signed [D_W-1:0] s2_dr, s2_di;

  logic signed [65:0]    s3_hr;
  logic signed [64:0]    s3_hi;
  logic signed [34:0]    s3_csr, s3_csi;
  logic signed [D_W-1:0] s3_dr, s3_di;

  logic [50:0]           s4_mhr_lo, s4_mhi_lo;
  logic signed [51:0]    s4_mhr_hi;
  logic signed [50:0]    s4_mhi_hi;
  logic signed [69:0]    s4_dsq_r, s4_dsq_i;
  logic signed [34:0]    s4_csr, s4_csi;
  logic signed [D_W-1:0] s4_dr, s4_di;

  logic signed [46:0]    s5_nr, s5_ni;
  logic [DEN_W-1:0]      s5_den;
  logic signed [34:0]    s5_csr, s5_csi;
  logic signed [D_W-1:0] s5_dr, s5_di;

  logic signed [56:0]    s6_rr_lo, s6_ri_lo, s6_ir_lo, s6_ii_lo;
  logic signed [54:0]    s6_rr_hi, s6_ri_hi, s6_ir_hi, s6_ii_hi;
  logic [DEN_W-1:0]      s6_den;
  logic signed [34:0]    s6_csr, s6_csi;

  logic signed [79:0]    s7_rr, s7_ri, s7_ir, s7_ii;
  logic [DEN_W-1:0]      s7_den;
  logic signed [34:0]    s7_csr, s7_csi;

  logic signed [79:0]    s8_tr, s8_ti;
  logic [DEN_W-1:0]      s8_den;
  logic signed [34:0]    s8_csr, s8_csi;

  logic signed [62:0]    s9_a0, s9_a1, s9_b0, s9_b1, s9_c0, s9_c1, s9_e0, s9_e1;
  logic signed [60:0]    s9_a2, s9_b2, s9_c2, s9_e2;
  logic [DEN_W-1:0]      s9_den;
  flag_t                 s9_flg;

  logic signed [MAG_W-1:0] s10_a, s10_b, s10_c, s10_e;
  logic [DEN_W-1:0]        s10_den;
  flag_t                   s10_flg;

  logic signed [MAG_W-1:0] s11_ur, s11_ui;
  logic [DEN_W-1:0]        s11_den;
  flag_t                   s11_flg;

  logic [MAG_W-1:0]        s12_magr, s12_magi;
  logic                    s12_negr, s12_negi;
  logic [DEN_W-1:0]        s12_den;
  flag_t                   s12_flg;

  logic signed [51:0] csr_sum, csi_sum;
  logic signed [85:0] nr_sum, ni_sum;

  assign csr_sum = 52'(s2_csr_raw) + CS_BIAS;
  assign csi_sum = 52'(s2_csi_raw) + CS_BIAS;
  assign nr_sum  = (86'(s4_mhr_hi) <<< 33) + $signed(86'(s4_mhr_lo)) + NR_BIAS;
  assign ni_sum  = (86'(s4_mhi_hi) <<< 33) + $signed(86'(s4_mhi_lo)) + NI_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dr <= data_re;
      s1_di <= data_im;

      // products of the table values, and sensing times the sensing gain
      s2_p_rr    <= s1_cr * s1_rr;
      s2_p_ii    <= s1_ci * s1_ri;
      s2_p_ri    <= s1_cr * s1_ri;
      s2_p_ir    <= s1_ci * s1_rr;
      s2_csr_raw <= s1_cr * $signed({1'b0, sensing_gain});
      s2_csi_raw <= s1_ci * $signed({1'b0, sensing_gain});
      s2_dr      <= s1_dr;
      s2_di      <= s1_di;

      // open-loop gain minus one, scaled sensing rounded to q.23
      s3_hr  <= 66'(s2_p_rr) - 66'(s2_p_ii) - ONE_Q46;
      s3_hi  <= 65'(s2_p_ri) + 65'(s2_p_ir);
      s3_csr <= csr_sum[50:16];
      s3_csi <= csi_sum[50:16];
      s3_dr  <= s2_dr;
      s3_di  <= s2_di;

      // gain product split in two halves
      s4_mhr_lo <= s3_hr[32:0] * open_loop_gain;
      s4_mhr_hi <= $signed(s3_hr[65:33]) * $signed({1'b0, open_loop_gain});
      s4_mhi_lo <= s3_hi[32:0] * open_loop_gain;
      s4_mhi_hi <= $signed(s3_hi[64:33]) * $signed({1'b0, open_loop_gain});
      s4_dsq_r  <= s3_csr * s3_csr;
      s4_dsq_i  <= s3_csi * s3_csi;
      s4_csr    <= s3_csr;
      s4_csi    <= s3_csi;
      s4_dr     <= s3_dr;
      s4_di     <= s3_di;

      // new numerator in q.23 with the plus one folded into the bias
      s5_nr  <= nr_sum[85:39];
      s5_ni  <= ni_sum[85:39];
      s5_den <= s4_dsq_r[DEN_W-1:0] + s4_dsq_i[DEN_W-1:0];
      s5_csr <= s4_csr;
      s5_csi <= s4_csi;
      s5_dr  <= s4_dr;
      s5_di  <= s4_di;

      s6_rr_lo <= $signed({1'b0, s5_nr[23:0]}) * s5_dr;
      s6_rr_hi <= $signed(s5_nr[46:24]) * s5_dr;
      s6_ri_lo <= $signed({1'b0, s5_nr[23:0]}) * s5_di;
      s6_ri_hi <= $signed(s5_nr[46:24]) * s5_di;
      s6_ir_lo <= $signed({1'b0, s5_ni[23:0]}) * s5_dr;
      s6_ir_hi <= $signed(s5_ni[46:24]) * s5_dr;
      s6_ii_lo <= $signed({1'b0, s5_ni[23:0]}) * s5_di;
      s6_ii_hi <= $signed(s5_ni[46:24]) * s5_di;
      s6_den   <= s5_den;
      s6_csr   <= s5_csr;
      s6_csi   <= s5_csi;

      s7_rr  <= (80'(s6_rr_hi) <<< 24) + 80'(s6_rr_lo);
      s7_ri  <= (80'(s6_ri_hi) <<< 24) + 80'(s6_ri_lo);
      s7_ir  <= (80'(s6_ir_hi) <<< 24) + 80'(s6_ir_lo);
      s7_ii  <= (80'(s6_ii_hi) <<< 24) + 80'(s6_ii_lo);
      s7_den <= s6_den;
      s7_csr <= s6_csr;
      s7_csi <= s6_csi;

      s8_tr  <= s7_rr - s7_ii;
      s8_ti  <= s7_ri + s7_ir;
      s8_den <= s7_den;
      s8_csr <= s7_csr;
      s8_csi <= s7_csi;

      // t times conj(cs), t cut in three slices
      s9_a0 <= $signed({1'b0, s8_tr[26:0]}) * s8_csr;
      s9_a1 <= $signed({1'b0, s8_tr[53:27]}) * s8_csr;
      s9_a2 <= $signed(s8_tr[79:54]) * s8_csr;
      s9_b0 <= $signed({1'b0, s8_ti[26:0]}) * s8_csi;
      s9_b1 <= $signed({1'b0, s8_ti[53:27]}) * s8_csi;
      s9_b2 <= $signed(s8_ti[79:54]) * s8_csi;
      s9_c0 <= $signed({1'b0, s8_ti[26:0]}) * s8_csr;
      s9_c1 <= $signed({1'b0, s8_ti[53:27]}) * s8_csr;
      s9_c2 <= $signed(s8_ti[79:54]) * s8_csr;
      s9_e0 <= $signed({1'b0, s8_tr[26:0]}) * s8_csi;
      s9_e1 <= $signed({1'b0, s8_tr[53:27]}) * s8_csi;
      s9_e2 <= $signed(s8_tr[79:54]) * s8_csi;
      s9_den <= s8_den;
      s9_flg <= '{zd: (s8_den == '0), tz_re: (s8_tr == '0), tn_re: s8_tr[79],
                  tz_im: (s8_ti == '0), tn_im: s8_ti[79]};

      s10_a <= (MAG_W'(s9_a2) <<< 54) + (MAG_W'(s9_a1) <<< 27) + MAG_W'(s9_a0);
      s10_b <= (MAG_W'(s9_b2) <<< 54) + (MAG_W'(s9_b1) <<< 27) + MAG_W'(s9_b0);
      s10_c <= (MAG_W'(s9_c2) <<< 54) + (MAG_W'(s9_c1) <<< 27) + MAG_W'(s9_c0);
      s10_e <= (MAG_W'(s9_e2) <<< 54) + (MAG_W'(s9_e1) <<< 27) + MAG_W'(s9_e0);
      s10_den <= s9_den;
      s10_flg <= s9_flg;

      s11_ur  <= s10_a + s10_b;
      s11_ui  <= s10_c - s10_e;
      s11_den <= s10_den;
      s11_flg <= s10_flg;

      s12_negr <= s11_ur[MAG_W-1];
      s12_negi <= s11_ui[MAG_W-1];
      s12_magr <= s11_ur[MAG_W-1] ? MAG_W'(-s11_ur) : s11_ur;
      s12_magi <= s11_ui[MAG_W-1] ? MAG_W'(-s11_ui) : s11_ui;
      s12_den  <= s11_den;
      s12_flg  <= s11_flg;
    end
  end

  // ---------------- divider: one quotient bit per stage
  lane_t            dre [0:DIV_STEPS];
  lane_t            dim [0:DIV_STEPS];
  logic [DEN_W-1:0] dden [0:DIV_STEPS];
  flag_t            dflg [0:DIV_STEPS];

  function automatic lane_t div_step(lane_t l, logic [DEN_W-1:0] d);
    logic [DEN_W:0] rt;
    logic           ge;
    lane_t          n;
    rt     = {l.rem, l.sh[Q_W-1]};
    ge     = rt >= {1'b0, d};
    n      = l;
    n.rem  = ge ? DEN_W'(rt - {1'b0, d}) : rt[DEN_W-1:0];
    n.sh   = {l.sh[Q_W-2:0], ge};
    return n;
  endfunction

  // a quotient of 2^33 or more saturates anyway
  function automatic lane_t div_init(logic [MAG_W-1:0] m, logic neg,
                                     logic [DEN_W-1:0] d);
    lane_t l;
    l.big = m[MAG_W-1:Q_W] >= (MAG_W-Q_W)'(d);
    l.rem = m[Q_W+DEN_W-1:Q_W];
    l.sh  = m[Q_W-1:0];
    l.neg = neg;
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dre[0]  <= div_init(s12_magr, s12_negr, s12_den);
      dim[0]  <= div_init(s12_magi, s12_negi, s12_den);
      dden[0] <= s12_den;
      dflg[0] <= s12_flg;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dre[k+1]  <= div_step(dre[k], dden[k]);
        dim[k+1]  <= div_step(dim[k], dden[k]);
        dden[k+1] <= dden[k];
        dflg[k+1] <= dflg[k];
      end
    end
  end

  // ---------------- rounding and saturation
  logic [Q_W:0] q_re, q_im;
  logic         neg_re, neg_im, big_re, big_im;
  flag_t        fin_flg;

  function automatic logic [Q_W:0] div_round(lane_t l, logic [DEN_W-1:0] d);
    logic up;
    up = {l.rem, 1'b0} >= {1'b0, d};
    return {1'b0, l.sh} + (Q_W+1)'(up);
  endfunction

  function automatic logic signed [D_W-1:0] sat_result(
      logic [Q_W:0] q, logic neg, logic big, logic zd, logic tz, logic tn);
    logic signed [D_W-1:0] r;
    if (zd) begin
      r = tz ? '0 : (tn ? SAT_MIN : SAT_MAX);
    end else if (!neg) begin
      r = (big || q > (Q_W+1)'(SAT_MAX)) ? SAT_MAX : q[D_W-1:0];
    end else begin
      r = (big || q > {2'b0, SAT_MIN}) ? SAT_MIN : D_W'(-q);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q_re    <= div_round(dre[DIV_STEPS], dden[DIV_STEPS]);
      q_im    <= div_round(dim[DIV_STEPS], dden[DIV_STEPS]);
      neg_re  <= dre[DIV_STEPS].neg;
      neg_im  <= dim[DIV_STEPS].neg;
      big_re  <= dre[DIV_STEPS].big;
      big_im  <= dim[DIV_STEPS].big;
      fin_flg <= dflg[DIV_STEPS];

      cal_re       <= sat_result(q_re, neg_re, big_re, fin_flg.zd,
                                 fin_flg.tz_re, fin_flg.tn_re);
      cal_im       <= sat_result(q_im, neg_im, big_im, fin_flg.zd,
                                 fin_flg.tz_im, fin_flg.tn_im);
      zero_divisor <= fin_flg.zd;
    end
  end

  assign out_valid = vld[LAT];
  assign bin_out   = meta[LAT].bin;
  assign last_out  = meta[LAT].last;

  // ---------------- checks
  `SBR_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result valid after reset")
  `SBR_ASSERT(a_stall_holds, !en |=> $stable(vld), "pipeline moved while stalled")
  `SBR_ASSERT(a_load_silent, (in_acc && action == ACT_LOAD) |=> !vld[1], "load made a result")
  `SBR_ASSERT(a_div_rem, (vld[DIV_BASE+DIV_STEPS] && !dflg[DIV_STEPS].zd && !dre[DIV_STEPS].big) |-> (dre[DIV_STEPS].rem < dden[DIV_STEPS]), "divider remainder out of range")
  `SBR_ASSERT(a_zd_sat, (out_valid && zero_divisor) |-> (cal_re == SAT_MAX || cal_re == SAT_MIN || cal_re == '0), "zero divisor output not saturated")

endmodule

`default_nettype wire

// File: rtl/core/sbr_ram.sv
// ----------------------------------------------------------------------------
// sbr_ram
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
